### hdl/b64c_pkg.sv
// b64c_pkg: shared types, character constants and alphabet functions
// for the base64 codec; no dependencies
`timescale 1ns / 1ps

package b64c_pkg;

  localparam logic [7:0] CH_PAD   = 8'h3D;
  localparam logic [7:0] CH_UPPER = 8'h41;
  localparam logic [7:0] CH_LOWER = 8'h61;
  localparam logic [7:0] CH_DIGIT = 8'h30;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [6:0] DEC_BAD  = 7'd64;

  localparam logic MODE_ENCODE = 1'b0;
  localparam logic MODE_DECODE = 1'b1;

  // up to four results produced by one input beat
  typedef struct packed {
    logic [3:0][7:0] data;
    logic [1:0]      last_idx;
    logic            stream_end;
    logic            error;
  } bundle_t;

  function automatic logic [7:0] enc_char(input logic [5:0] v);
    logic [7:0] w;
    w = {2'b00, v};
    if (v < 6'd26) begin
      return CH_UPPER + w;
    end else if (v < 6'd52) begin
      return CH_LOWER + w - 8'd26;
    end else if (v < 6'd62) begin
      return CH_DIGIT + w - 8'd52;
    end else if (v == 6'd62) begin
      return CH_PLUS;
    end else begin
      return CH_SLASH;
    end
  endfunction

  // returns 0..63, or DEC_BAD for a character outside the alphabet
  function automatic logic [6:0] dec_value(input logic [7:0] c);
    logic [7:0] d;
    d = 8'd0;
    if (c >= CH_UPPER && c <= 8'h5A) begin
      d = c - CH_UPPER;
      return {1'b0, d[5:0]};
    end else if (c >= CH_LOWER && c <= 8'h7A) begin
      d = c - CH_LOWER + 8'd26;
      return {1'b0, d[5:0]};
    end else if (c >= CH_DIGIT && c <= 8'h39) begin
      d = c - CH_DIGIT + 8'd52;
      return {1'b0, d[5:0]};
    end else if (c == CH_PLUS) begin
      return 7'd62;
    end else if (c == CH_SLASH) begin
      return 7'd63;
    end else begin
      return DEC_BAD;
    end
  endfunction

endpackage

### hdl/base64_codec.sv
// base64_codec: top level of the streaming base64 codec
// depends on b64c_pkg, b64c_core and b64c_out
`timescale 1ns / 1ps

// Base64 codec, standard alphabet, one byte or character per input beat.
// cfg_data selects the mode (0 encode, 1 decode); a write starts a new stream
// and belongs between streams, while the block is idle. Each input beat is
// processed in the cycle it is accepted and its results (none to four) land in
// an output register that hands out one result per cycle while out_ready is
// high. The next input beat is taken in the same cycle that the last result of
// the previous one leaves, or at once if that beat produced none. The input
// thus waits while the results of an encoded or decoded group drain. In decode
// mode a bad character or bad length gives a single error result at the last
// beat.

module base64_codec (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic       cfg_data,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_byte,
  input  logic       in_last,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_byte,
  output logic       out_run_end,
  output logic       out_stream_end,
  output logic       out_error
);

  logic              mode;
  logic              cfg_fire;
  logic              in_fire;
  logic              emit;
  logic              can_load;
  b64c_pkg::bundle_t bundle;

  assign cfg_ready = 1'b1;
  assign cfg_fire  = cfg_valid && cfg_ready;
  assign in_ready  = can_load;
  assign in_fire   = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= b64c_pkg::MODE_ENCODE;
    end else if (cfg_fire) begin
      mode <= cfg_data;
    end
  end

  b64c_core u_core (
    .clk     (clk),
    .rst     (rst),
    .mode    (mode),
    .clear   (cfg_fire),
    .in_fire (in_fire),
    .in_byte (in_byte),
    .in_last (in_last),
    .emit    (emit),
    .bundle  (bundle)
  );

  b64c_out u_out (
    .clk            (clk),
    .rst            (rst),
    .load           (emit),
    .bundle         (bundle),
    .can_load       (can_load),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_byte       (out_byte),
    .out_run_end    (out_run_end),
    .out_stream_end (out_stream_end),
    .out_error      (out_error)
  );

  a_error_ends_stream: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_error |-> out_run_end && out_stream_end && out_byte == 8'h00)
    else $error("error beat must close the stream");

  a_stream_end_is_run_end: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stream_end |-> out_run_end)
    else $error("stream end without run end");

  a_encode_no_error: assert property (@(posedge clk) disable iff (rst)
    out_valid && mode == b64c_pkg::MODE_ENCODE |-> !out_error)
    else $error("error beat in encode mode");

  a_idle_accepts: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("input stalled with empty output register");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    emit |-> !out_valid || (out_ready && out_run_end))
    else $error("bundle loaded over pending results");

endmodule

### hdl/b64c_core.sv
// b64c_core: group state registers and per-beat encode/decode logic,
// producing a result bundle; depends on b64c_pkg
`timescale 1ns / 1ps

module b64c_core (
  input  logic              clk,
  input  logic              rst,
  input  logic              mode,
  input  logic              clear,
  input  logic              in_fire,
  input  logic [7:0]        in_byte,
  input  logic              in_last,
  output logic              emit,
  output b64c_pkg::bundle_t bundle
);

  logic [23:0] group_bits;
  logic [1:0]  group_count;
  logic        third_was_pad;
  logic        error_seen;

  logic [23:0] group_bits_next;
  logic [1:0]  group_count_next;
  logic        third_was_pad_next;
  logic        error_seen_next;

  logic [2:0]  cnt;
  logic [23:0] bits_e;
  logic [23:0] sh;
  logic [6:0]  dv;
  logic        pad;
  logic        bad;
  logic [5:0]  v;
  logic        err_n;
  logic        twp_n;
  logic [23:0] bits_d;

  always_comb begin
    group_bits_next    = group_bits;
    group_count_next   = group_count;
    third_was_pad_next = third_was_pad;
    error_seen_next    = error_seen;
    emit               = 1'b0;
    bundle             = '0;

    cnt = {1'b0, group_count} + 3'd1;
    if (cnt > 3'd3) begin
      cnt = 3'd3;
    end
    bits_e = {group_bits[15:0], in_byte};
    unique case (cnt)
      3'd1:    sh = {bits_e[7:0], 16'h0000};
      3'd2:    sh = {bits_e[15:0], 8'h00};
      default: sh = bits_e;
    endcase

    dv     = b64c_pkg::dec_value(in_byte);
    pad    = (in_byte == b64c_pkg::CH_PAD);
    bad    = !pad && (dv == b64c_pkg::DEC_BAD);
    v      = (pad || bad) ? 6'd0 : dv[5:0];
    err_n  = error_seen || bad;
    twp_n  = (group_count == 2'd2) ? pad : third_was_pad;
    bits_d = {group_bits[17:0], v};

    if (mode == b64c_pkg::MODE_ENCODE) begin
      if (cnt < 3'd3 && !in_last) begin
        group_bits_next  = bits_e;
        group_count_next = cnt[1:0];
      end else begin
        emit = 1'b1;
        for (int k = 0; k < 4; k++) begin
          if (3'(k) > cnt) begin
            bundle.data[k] = b64c_pkg::CH_PAD;
          end else begin
            bundle.data[k] = b64c_pkg::enc_char(sh[23 - 6 * k -: 6]);
          end
        end
        bundle.last_idx    = 2'd3;
        bundle.stream_end  = in_last;
        group_bits_next    = '0;
        group_count_next   = '0;
        third_was_pad_next = 1'b0;
        error_seen_next    = 1'b0;
      end
    end else begin
      bundle.data[0] = bits_d[23:16];
      bundle.data[1] = bits_d[15:8];
      bundle.data[2] = bits_d[7:0];
      if (in_last) begin
        emit = 1'b1;
        bundle.stream_end = 1'b1;
        if (err_n || group_count != 2'd3) begin
          bundle.data     = '0;
          bundle.last_idx = 2'd0;
          bundle.error    = 1'b1;
        end else begin
          bundle.last_idx = 2'd2 - {1'b0, twp_n} - {1'b0, pad};
        end
        group_bits_next    = '0;
        group_count_next   = '0;
        third_was_pad_next = 1'b0;
        error_seen_next    = 1'b0;
      end else if (group_count == 2'd3) begin
        emit               = !err_n;
        bundle.last_idx    = 2'd2;
        group_bits_next    = '0;
        group_count_next   = '0;
        third_was_pad_next = 1'b0;
        error_seen_next    = err_n;
      end else begin
        group_bits_next    = bits_d;
        group_count_next   = group_count + 2'd1;
        third_was_pad_next = twp_n;
        error_seen_next    = err_n;
      end
    end
    emit = emit && in_fire;
  end

  always_ff @(posedge clk) begin
    if (rst || clear) begin
      group_bits    <= '0;
      group_count   <= '0;
      third_was_pad <= 1'b0;
      error_seen    <= 1'b0;
    end else if (in_fire) begin
      group_bits    <= group_bits_next;
      group_count   <= group_count_next;
      third_was_pad <= third_was_pad_next;
      error_seen    <= error_seen_next;
    end
  end

endmodule

### hdl/b64c_out.sv
// b64c_out: result register that holds one bundle and hands its results
// out one beat at a time; depends on b64c_pkg
`timescale 1ns / 1ps

module b64c_out (
  input  logic              clk,
  input  logic              rst,
  input  logic              load,
  input  b64c_pkg::bundle_t bundle,
  output logic              can_load,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [7:0]        out_byte,
  output logic              out_run_end,
  output logic              out_stream_end,
  output logic              out_error
);

  b64c_pkg::bundle_t held;
  logic [1:0]        idx;
  logic              valid;
  logic              final_beat;

  assign final_beat     = (idx == held.last_idx);
  assign can_load       = !valid || (out_ready && final_beat);
  assign out_valid      = valid;
  assign out_byte       = held.data[idx];
  assign out_run_end    = final_beat;
  assign out_stream_end = final_beat && held.stream_end;
  assign out_error      = held.error;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
      idx   <= '0;
    end else if (load) begin
      valid <= 1'b1;
      idx   <= '0;
    end else if (valid && out_ready) begin
      if (final_beat) begin
        valid <= 1'b0;
      end else begin
        idx <= idx + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      held <= bundle;
    end
  end

endmodule

### dv/tb_base64_codec.sv
// tb_base64_codec: self-checking testbench for the base64 codec in both modes,
// directed and random streams with random stalls on the input and output channels
// depends on b64c_pkg and base64_codec
`timescale 1ns / 1ps

module tb_base64_codec;

  localparam int WATCHDOG_LIMIT = 1000;
  localparam int SETTLE_CYCLES  = 4;
  localparam logic [8*64-1:0] SYMBOLS =
    "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";
  localparam logic [6:0] NOT_SYMBOL = 7'd64;

  typedef enum int {FLAW_NONE, FLAW_BAD_CHAR, FLAW_BAD_LENGTH, FLAW_MID_PAD, FLAW_NOISE} flaw_t;

  typedef struct packed {
    logic [7:0] data;
    logic       run_end;
    logic       stream_end;
    logic       error;
  } b64_result_t;

  typedef logic [7:0] byte_q_t [$];

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       cfg_valid = 1'b0;
  logic       cfg_ready;
  logic       cfg_data = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [7:0] in_byte = 8'h00;
  logic       in_last = 1'b0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [7:0] out_byte;
  logic       out_run_end;
  logic       out_stream_end;
  logic       out_error;

  // codec state as predicted
  logic        cur_mode = b64c_pkg::MODE_ENCODE;
  logic [23:0] grp_bits = '0;
  logic [1:0]  grp_count = '0;
  logic        grp_third_pad = 1'b0;
  logic        grp_error = 1'b0;

  b64_result_t pending_results [$];
  int          fail_count = 0;
  int          beats_sent = 0;
  int          idle_cycles = 0;
  int          out_stall = 0;
  int          out_gap;
  bit          no_gaps = 1'b0;

  base64_codec dut (
    .clk            (clk),
    .rst            (rst),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_data       (cfg_data),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_byte        (in_byte),
    .in_last        (in_last),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_byte       (out_byte),
    .out_run_end    (out_run_end),
    .out_stream_end (out_stream_end),
    .out_error      (out_error)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (no_gaps || r < 55) begin
      return 0;
    end else if (r < 92) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [7:0] symbol_of(input logic [5:0] v);
    return SYMBOLS[8*(63 - int'(v)) +: 8];
  endfunction

  function automatic logic [6:0] value_of(input logic [7:0] c);
    for (int i = 0; i < 64; i++) begin
      if (symbol_of(i[5:0]) == c) begin
        return i[6:0];
      end
    end
    return NOT_SYMBOL;
  endfunction

  function automatic logic [7:0] bad_symbol();
    logic [7:0] c;
    do begin
      c = 8'($urandom_range(0, 255));
    end while (value_of(c) != NOT_SYMBOL || c == b64c_pkg::CH_PAD);
    return c;
  endfunction

  function automatic void clear_group();
    grp_bits      = '0;
    grp_count     = '0;
    grp_third_pad = 1'b0;
    grp_error     = 1'b0;
  endfunction

  function automatic void push_result(input logic [7:0] data, input logic run_end,
                                      input logic stream_end, input logic error);
    b64_result_t r;
    r.data       = data;
    r.run_end    = run_end;
    r.stream_end = stream_end;
    r.error      = error;
    pending_results.push_back(r);
  endfunction

  function automatic void predict_beat(input logic [7:0] b, input logic last);
    logic [23:0] bits;
    logic [6:0]  v;
    logic        pad;
    int          cnt;
    int          n;
    if (cur_mode == b64c_pkg::MODE_ENCODE) begin
      cnt  = int'(grp_count) + 1;
      bits = {grp_bits[15:0], b};
      if (cnt < 3 && !last) begin
        grp_bits  = bits;
        grp_count = cnt[1:0];
      end else begin
        bits = bits << (8 * (3 - cnt));
        for (int k = 0; k < 4; k++) begin
          push_result((k > cnt) ? b64c_pkg::CH_PAD : symbol_of(bits[18 - 6*k +: 6]),
                      k == 3, (k == 3) && last, 1'b0);
        end
        clear_group();
      end
    end else begin
      pad = (b == b64c_pkg::CH_PAD);
      v   = pad ? 7'd0 : value_of(b);
      if (v == NOT_SYMBOL) begin
        grp_error = 1'b1;
        v = 7'd0;
      end
      grp_bits = {grp_bits[17:0], v[5:0]};
      if (grp_count == 2'd2) begin
        grp_third_pad = pad;
      end
      if (last) begin
        if (grp_error || grp_count != 2'd3) begin
          push_result(8'h00, 1'b1, 1'b1, 1'b1);
        end else begin
          n = 3 - int'(grp_third_pad) - int'(pad);
          for (int k = 0; k < n; k++) begin
            push_result(grp_bits[16 - 8*k +: 8], k == n - 1, k == n - 1, 1'b0);
          end
        end
        clear_group();
      end else if (grp_count == 2'd3) begin
        if (!grp_error) begin
          for (int k = 0; k < 3; k++) begin
            push_result(grp_bits[16 - 8*k +: 8], k == 2, 1'b0, 1'b0);
          end
        end
        grp_bits      = '0;
        grp_count     = '0;
        grp_third_pad = 1'b0;
      end else begin
        grp_count = grp_count + 2'd1;
      end
    end
  endfunction

  function automatic void check_field(input string what, input logic [7:0] want,
                                      input logic [7:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %h actual %h", $time, what, want, got);
      fail_count++;
    end
  endfunction

  // output side: random backpressure
  always @(posedge clk) begin
    if (out_stall > 0) begin
      out_ready <= 1'b0;
      out_stall = out_stall - 1;
    end else begin
      out_gap = pick_gap();
      out_ready <= (out_gap == 0);
      out_stall = (out_gap > 0) ? out_gap - 1 : 0;
    end
  end

  // result checker
  always @(posedge clk) begin
    b64_result_t want;
    if (!rst && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual byte %h run_end %b %s %b %s %b",
                 $time, out_byte, out_run_end, "stream_end", out_stream_end,
                 "error", out_error);
        fail_count++;
      end else begin
        want = pending_results.pop_front();
        check_field("out_byte", want.data, out_byte);
        check_field("out_run_end", 8'(want.run_end), 8'(out_run_end));
        check_field("out_stream_end", 8'(want.stream_end), 8'(out_stream_end));
        check_field("out_error", 8'(want.error), 8'(out_error));
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: watchdog expired", $time);
      $display("FAILURE");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic send_beat(input logic [7:0] b, input logic last);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_byte  <= b;
    in_last  <= last;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predict_beat(b, last);
    beats_sent++;
  endtask

  task automatic send_text(input string s, input bit mark_last);
    for (int i = 0; i < s.len(); i++) begin
      send_beat(s[i], mark_last && (i == s.len() - 1));
    end
  endtask

  task automatic send_bytes(input byte_q_t q, input bit mark_last);
    for (int i = 0; i < q.size(); i++) begin
      send_beat(q[i], mark_last && (i == q.size() - 1));
    end
  endtask

  // drain all expected results, then let the datapath go quiet
  task automatic settle();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_mode(input logic m);
    settle();
    cfg_valid <= 1'b1;
    cfg_data  <= m;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    cur_mode = m;
    clear_group();
  endtask

  task automatic test_encode_groups();
    write_mode(b64c_pkg::MODE_ENCODE);
    send_beat(8'h00, 1'b1);
    send_beat(8'hFF, 1'b0);
    send_beat(8'hFF, 1'b1);
    send_text("Man", 1'b1);
  endtask

  task automatic test_decode_padding();
    write_mode(b64c_pkg::MODE_DECODE);
    send_text("TQ==", 1'b1);
    send_text("TWE=", 1'b1);
    send_text("=9+/", 1'b1);
  endtask

  task automatic test_decode_errors();
    send_text("Zg\377=", 1'b1);
    send_text("Zm9", 1'b1);
  endtask

  task automatic test_random_encode(input int count);
    byte_q_t q;
    int      stop;
    int      streams;
    int      len;
    write_mode(b64c_pkg::MODE_ENCODE);
    stop    = beats_sent + count;
    streams = 0;
    while (beats_sent < stop) begin
      no_gaps = (streams < 3);
      len = ($urandom_range(0, 9) < 8) ? $urandom_range(1, 9) : $urandom_range(10, 24);
      q.delete();
      repeat (len) q.push_back(8'($urandom_range(0, 255)));
      send_bytes(q, 1'b1);
      streams++;
    end
    no_gaps = 1'b0;
  endtask

  task automatic test_random_decode(input int count);
    byte_q_t q;
    flaw_t   flaw;
    int      stop;
    int      groups;
    int      r;
    write_mode(b64c_pkg::MODE_DECODE);
    stop = beats_sent + count;
    while (beats_sent < stop) begin
      groups = ($urandom_range(0, 9) < 8) ? $urandom_range(1, 3) : $urandom_range(4, 8);
      q.delete();
      repeat (4 * groups) q.push_back(symbol_of(6'($urandom_range(0, 63))));
      r = $urandom_range(0, 99);
      if (r < 65) begin
        flaw = FLAW_NONE;
      end else if (r < 77) begin
        flaw = FLAW_BAD_CHAR;
      end else if (r < 87) begin
        flaw = FLAW_BAD_LENGTH;
      end else if (r < 95) begin
        flaw = FLAW_MID_PAD;
      end else begin
        flaw = FLAW_NOISE;
      end
      case (flaw)
        FLAW_NONE: begin
          r = $urandom_range(0, 2);
          for (int i = 0; i < r; i++) q[q.size() - 1 - i] = b64c_pkg::CH_PAD;
        end
        FLAW_BAD_CHAR: begin
          q[$urandom_range(0, q.size() - 1)] = bad_symbol();
        end
        FLAW_BAD_LENGTH: begin
          repeat ($urandom_range(1, 3)) void'(q.pop_back());
        end
        FLAW_MID_PAD: begin
          q[$urandom_range(0, q.size() - 1)] = b64c_pkg::CH_PAD;
        end
        default: begin
          foreach (q[i]) q[i] = 8'($urandom_range(0, 255));
        end
      endcase
      send_bytes(q, 1'b1);
    end
  endtask

  // streams cut short by a mode write must leave nothing behind
  task automatic test_mode_switch();
    byte_q_t q;
    repeat (3) begin
      write_mode(b64c_pkg::MODE_ENCODE);
      repeat ($urandom_range(1, 2)) send_beat(8'($urandom_range(0, 255)), 1'b0);
      write_mode(b64c_pkg::MODE_DECODE);
      q.delete();
      repeat ($urandom_range(1, 7)) q.push_back(symbol_of(6'($urandom_range(0, 63))));
      if ($urandom_range(0, 1)) q[$urandom_range(0, q.size() - 1)] = bad_symbol();
      send_bytes(q, 1'b0);
      write_mode(b64c_pkg::MODE_DECODE);
      send_text("TWFu", 1'b1);
      write_mode(b64c_pkg::MODE_ENCODE);
      send_text("Ma", 1'b1);
    end
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    test_encode_groups();
    test_decode_padding();
    test_decode_errors();
    test_random_encode(50);
    test_random_decode(60);
    test_mode_switch();
    settle();
    if (fail_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

### files.f
hdl/b64c_pkg.sv
hdl/b64c_core.sv
hdl/b64c_out.sv
hdl/base64_codec.sv
dv/tb_base64_codec.sv
